// File: design/tip_pkg.sv
// Shared types and constants for the tagged interval profiler.
package tip_pkg;

    localparam int TAG_W   = 16;
    localparam int TS_W    = 64;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 32;
    localparam int IDX_LIM = 2 ** IDX_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [TS_W-1:0]  TIME_MAX  = {TS_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } tip_action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_UNUSED    = 2'd3
    } tip_status_t;

    typedef struct packed {
        tip_action_t      action;
        logic [TAG_W-1:0] tag_id;
        logic [TS_W-1:0]  timestamp;
        logic [IDX_W-1:0] read_slot;
    } tip_in_t;

    typedef struct packed {
        tip_status_t      status;
        logic [IDX_W-1:0] slot_index;
        logic [TAG_W-1:0] slot_tag;
        logic [CNT_W-1:0] call_count;
        logic [TS_W-1:0]  total_time;
        logic [TS_W-1:0]  low_time;
        logic [TS_W-1:0]  high_time;
    } tip_out_t;

    // A request travelling along the chain, together with its result so far.
    typedef struct packed {
        tip_in_t  req;
        logic     resolved;
        tip_out_t result;
    } tip_pkt_t;

endpackage

// File: design/tip_cell.sv
// One slot of the profiler table, passing requests on to the next slot.
module tip_cell #(
    parameter int INDEX    = 0,
    parameter int TAG_BITS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  tip_pkg::tip_pkt_t in_pkt,
    output logic            out_valid,
    output tip_pkg::tip_pkt_t out_pkt
);
    import tip_pkg::*;

    localparam int KEY_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(INDEX);
    localparam logic             ADDRESSABLE = (INDEX < IDX_LIM);

    logic             valid_reg;
    tip_pkt_t         pkt_reg, pkt_next;
    logic             used_reg, used_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [TS_W-1:0]  start_reg, start_next;
    logic [TS_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [TS_W-1:0]  min1_reg, min1_next;
    logic [TS_W-1:0]  min2_reg, min2_next;
    logic [TS_W-1:0]  max1_reg, max1_next;
    logic [TS_W-1:0]  max2_reg, max2_next;

    logic             key_hit;
    logic             hit;
    logic             few;
    logic [TS_W-1:0]  interval;

    assign key_hit  = used_reg && (key_reg == in_pkt.req.tag_id[KEY_W-1:0]);
    assign interval = in_pkt.req.timestamp - start_reg;

    always_comb begin
        pkt_next   = in_pkt;
        used_next  = used_reg;
        key_next   = key_reg;
        start_next = start_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        min1_next  = min1_reg;
        min2_next  = min2_reg;
        max1_next  = max1_reg;
        max2_next  = max2_reg;
        hit        = 1'b0;

        if (in_valid && !in_pkt.resolved) begin
            unique case (in_pkt.req.action)
                ACT_START: begin
                    if (!used_reg) begin
                        used_next  = 1'b1;
                        key_next   = in_pkt.req.tag_id[KEY_W-1:0];
                        sum_next   = '0;
                        cnt_next   = '0;
                        min1_next  = TIME_MAX;
                        min2_next  = TIME_MAX;
                        max1_next  = '0;
                        max2_next  = '0;
                        start_next = in_pkt.req.timestamp;
                        hit        = 1'b1;
                    end else if (key_hit) begin
                        start_next = in_pkt.req.timestamp;
                        hit        = 1'b1;
                    end
                end
                ACT_STOP: begin
                    // Used slots form a prefix, so the first free slot ends the search.
                    if (!used_reg) begin
                        pkt_next.resolved = 1'b1;
                    end else if (key_hit) begin
                        if (interval < min1_reg) begin
                            min2_next = min1_reg;
                            min1_next = interval;
                        end else if (interval < min2_reg) begin
                            min2_next = interval;
                        end
                        if (interval > max1_reg) begin
                            max2_next = max1_reg;
                            max1_next = interval;
                        end else if (interval > max2_reg) begin
                            max2_next = interval;
                        end
                        sum_next = sum_reg + interval;
                        if (cnt_reg != COUNT_MAX) begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        hit = 1'b1;
                    end
                end
                ACT_CLEAR: begin
                    used_next = 1'b0;
                end
                ACT_READ: begin
                    if (ADDRESSABLE && used_reg && (in_pkt.req.read_slot == CELL_IDX)) begin
                        hit = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        few = (cnt_next <= CNT_W'(2));
        if (hit) begin
            pkt_next.resolved          = 1'b1;
            pkt_next.result.status     = ST_OK;
            pkt_next.result.slot_index = CELL_IDX;
            pkt_next.result.slot_tag   = TAG_W'(key_next);
            pkt_next.result.call_count = cnt_next;
            pkt_next.result.total_time = sum_next;
            pkt_next.result.low_time   = few ? min1_next : min2_next;
            pkt_next.result.high_time  = few ? max1_next : max2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            used_reg  <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pkt_reg   <= pkt_next;
            key_reg   <= key_next;
            start_reg <= start_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            min1_reg  <= min1_next;
            min2_reg  <= min2_next;
            max1_reg  <= max1_next;
            max2_reg  <= max2_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pkt   = pkt_reg;

endmodule

// File: design/tagged_interval_profiler_unit.sv
// One transaction per cycle while the result side does not stall; each request
// walks the row of slot cells in order, one cell per cycle, and every cell
// handles the requests in arrival order.
// A stalled result freezes the whole row, so s_ready follows the output stage.
// Reset (synchronous, active low) empties the table and drops requests in flight;
// the slot statistics themselves are not cleared.
module tagged_interval_profiler_unit #(
    parameter int SLOTS    = 64,
    parameter int TAG_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tip_pkg::tip_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tip_pkg::tip_out_t m_data
);
    import tip_pkg::*;

    logic             advance;
    logic [SLOTS:0]   chain_valid;
    tip_pkt_t         chain_pkt [SLOTS+1];
    tip_pkt_t         entry_pkt;

    // The result starts as the answer for a request that no slot claims.
    always_comb begin
        entry_pkt          = '0;
        entry_pkt.req      = s_data;
        entry_pkt.resolved = 1'b0;
        unique case (s_data.action)
            ACT_START: entry_pkt.result.status = ST_FULL;
            ACT_STOP:  entry_pkt.result.status = ST_NOT_FOUND;
            ACT_CLEAR: entry_pkt.result.status = ST_OK;
            ACT_READ: begin
                entry_pkt.result.status     = ST_UNUSED;
                entry_pkt.result.slot_index = s_data.read_slot;
            end
            default: entry_pkt.result.status = ST_OK;
        endcase
    end

    assign advance        = !chain_valid[SLOTS] || m_ready;
    assign s_ready        = advance;
    assign chain_valid[0] = s_valid;
    assign chain_pkt[0]   = entry_pkt;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        tip_cell #(
            .INDEX    (i),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_pkt    (chain_pkt[i]),
            .out_valid (chain_valid[i+1]),
            .out_pkt   (chain_pkt[i+1])
        );
    end

    assign m_valid = chain_valid[SLOTS];
    assign m_data  = chain_pkt[SLOTS].result;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the tagged interval profiler unit.
module testbench;
    import tip_pkg::*;

    localparam int NSLOTS = IDX_LIM;

    // Tracks the profiling table and the reports that the unit owes.
    class interval_scoreboard;
        bit               used [NSLOTS];
        logic [TAG_W-1:0] key [NSLOTS];
        logic [TS_W-1:0]  started_at [NSLOTS];
        logic [TS_W-1:0]  total [NSLOTS];
        logic [CNT_W-1:0] count [NSLOTS];
        logic [TS_W-1:0]  min1 [NSLOTS];
        logic [TS_W-1:0]  min2 [NSLOTS];
        logic [TS_W-1:0]  max1 [NSLOTS];
        logic [TS_W-1:0]  max2 [NSLOTS];
        tip_out_t         owed_reports [$];
        int               mismatches;

        function tip_out_t slot_report(int i);
            tip_out_t r;
            bit few;
            few = (count[i] <= 2);
            r = '0;
            r.status = ST_OK;
            r.slot_index = IDX_W'(i);
            r.slot_tag = key[i];
            r.call_count = count[i];
            r.total_time = total[i];
            r.low_time = few ? min1[i] : min2[i];
            r.high_time = few ? max1[i] : max2[i];
            return r;
        endfunction

        function void note_request(tip_in_t req);
            tip_out_t r;
            logic [TS_W-1:0] d;
            bit done;
            r = '0;
            done = 0;
            case (req.action)
                ACT_START: begin
                    r.status = ST_FULL;
                    for (int i = 0; i < NSLOTS && !done; i++) begin
                        if (!used[i]) begin
                            used[i] = 1;
                            key[i] = req.tag_id;
                            total[i] = '0;
                            count[i] = '0;
                            min1[i] = TIME_MAX;
                            min2[i] = TIME_MAX;
                            max1[i] = '0;
                            max2[i] = '0;
                            started_at[i] = req.timestamp;
                            r = slot_report(i);
                            done = 1;
                        end else if (key[i] == req.tag_id) begin
                            started_at[i] = req.timestamp;
                            r = slot_report(i);
                            done = 1;
                        end
                    end
                end
                ACT_STOP: begin
                    r.status = ST_NOT_FOUND;
                    for (int i = 0; i < NSLOTS && !done; i++) begin
                        if (!used[i]) begin
                            done = 1;
                        end else if (key[i] == req.tag_id) begin
                            d = req.timestamp - started_at[i];
                            if (d < min1[i]) begin
                                min2[i] = min1[i];
                                min1[i] = d;
                            end else if (d < min2[i]) begin
                                min2[i] = d;
                            end
                            if (d > max1[i]) begin
                                max2[i] = max1[i];
                                max1[i] = d;
                            end else if (d > max2[i]) begin
                                max2[i] = d;
                            end
                            total[i] = total[i] + d;
                            if (count[i] != COUNT_MAX) count[i] = count[i] + 1;
                            r = slot_report(i);
                            done = 1;
                        end
                    end
                end
                ACT_CLEAR: begin
                    for (int i = 0; i < NSLOTS; i++) used[i] = 0;
                    r.status = ST_OK;
                end
                default: begin
                    if (used[req.read_slot]) begin
                        r = slot_report(int'(req.read_slot));
                    end else begin
                        r.status = ST_UNUSED;
                        r.slot_index = req.read_slot;
                    end
                end
            endcase
            owed_reports.push_back(r);
        endfunction

        function void check_report(tip_out_t got);
            tip_out_t want;
            if (owed_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: status %0d slot %0d tag %h",
                             got.status, got.slot_index, got.slot_tag);
                return;
            end
            want = owed_reports.pop_front();
            if (got.status !== want.status || got.slot_index !== want.slot_index ||
                got.slot_tag !== want.slot_tag || got.call_count !== want.call_count ||
                got.total_time !== want.total_time || got.low_time !== want.low_time ||
                got.high_time !== want.high_time) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Result mismatch\n",
                              "  expected: status %0d slot %0d tag %h count %h total %h",
                              " low %h high %h\n",
                              "  actual:   status %0d slot %0d tag %h count %h total %h",
                              " low %h high %h"},
                             want.status, want.slot_index, want.slot_tag, want.call_count,
                             want.total_time, want.low_time, want.high_time,
                             got.status, got.slot_index, got.slot_tag, got.call_count,
                             got.total_time, got.low_time, got.high_time);
            end
        endfunction

        function int outstanding();
            return owed_reports.size();
        endfunction
    endclass

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    tip_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    tip_out_t m_data;

    interval_scoreboard sb = new;
    bit                 quiet_phase;
    int                 sent_count;
    logic [TS_W-1:0]    tick_now;

    tagged_interval_profiler_unit #(
        .SLOTS(NSLOTS),
        .TAG_BITS(TAG_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("[tagged_interval_profiler_unit] ERROR");
        $finish;
    end

    // Mostly short gaps, now and then a long one; none at all in a quiet phase.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: check every accepted transaction and stall at random.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_report(m_data);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    task automatic send_request(input tip_in_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_request(req);
        sent_count++;
    endtask

    task automatic issue(input tip_action_t act, input logic [TAG_W-1:0] tag,
                         input logic [TS_W-1:0] ts, input logic [IDX_W-1:0] slot);
        tip_in_t req;
        req.action = act;
        req.tag_id = tag;
        req.timestamp = ts;
        req.read_slot = slot;
        send_request(req);
    endtask

    task automatic pause_until_drained();
        if (sb.outstanding() != 0) begin
            s_valid <= 1'b0;
            while (sb.outstanding() != 0) @(posedge aclk);
        end
    endtask

    task automatic issue_noise();
        repeat ($urandom_range(3, 12))
            issue(tip_action_t'($urandom_range(0, 3)), TAG_W'($urandom),
                  {$urandom, $urandom}, IDX_W'($urandom));
    endtask

    // Starts, stops and reads on a few tags, maybe after a clear; the tick mostly rises.
    task automatic run_session();
        logic [TAG_W-1:0] pool [6];
        int pool_n;
        int r;
        logic [TAG_W-1:0] tag;
        pool_n = $urandom_range(1, 6);
        for (int k = 0; k < pool_n; k++) pool[k] = TAG_W'($urandom);
        if ($urandom_range(0, 2) == 0)
            issue(ACT_CLEAR, TAG_W'($urandom), {$urandom, $urandom}, IDX_W'($urandom));
        repeat ($urandom_range(6, 30)) begin
            r = $urandom_range(0, 15);
            if (r == 0) tick_now = {$urandom, $urandom};
            else if (r < 5) tick_now = tick_now + TS_W'($urandom_range(0, 3));
            else if (r < 15) tick_now = tick_now + TS_W'($urandom_range(0, 2000));
            else tick_now = tick_now + {$urandom, $urandom};
            tag = pool[$urandom_range(0, pool_n - 1)];
            r = $urandom_range(0, 99);
            if (r < 45) issue(ACT_START, tag, tick_now, IDX_W'($urandom));
            else if (r < 90) issue(ACT_STOP, tag, tick_now, IDX_W'($urandom));
            else issue(ACT_READ, tag, tick_now,
                       IDX_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom));
        end
    endtask

    // Clears, fills the table, then tries a new tag, restarts, stops and reads one slot.
    task automatic fill_table();
        logic [TAG_W-1:0] base;
        base = TAG_W'($urandom);
        issue(ACT_CLEAR, TAG_W'($urandom), {$urandom, $urandom}, IDX_W'($urandom));
        for (int k = 0; k < NSLOTS; k++)
            issue(ACT_START, TAG_W'(base + k), {$urandom, $urandom}, IDX_W'($urandom));
        issue(ACT_START, TAG_W'(base + NSLOTS), {$urandom, $urandom}, IDX_W'($urandom));
        issue(ACT_START, TAG_W'(base + 5), {$urandom, $urandom}, IDX_W'($urandom));
        issue(ACT_STOP, TAG_W'(base + NSLOTS - 1), {$urandom, $urandom}, IDX_W'($urandom));
        issue(ACT_STOP, TAG_W'(base + NSLOTS + 1), {$urandom, $urandom}, IDX_W'($urandom));
        issue(ACT_READ, base, {$urandom, $urandom}, IDX_W'(NSLOTS - 1));
    endtask

    initial begin
        int pick;
        tick_now = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        issue(ACT_READ, 16'h0000, '0, 6'd0);
        issue(ACT_STOP, 16'h1234, '0, 6'd0);
        issue(ACT_START, 16'hFFFF, TIME_MAX - 64'd15, 6'h3F);
        // The stop stamp is below the start stamp, so the interval wraps.
        issue(ACT_STOP, 16'hFFFF, 64'h10, 6'd0);
        issue(ACT_START, 16'h0000, '0, 6'd0);
        issue(ACT_STOP, 16'h0000, TIME_MAX, 6'd0);
        issue(ACT_START, 16'h0000, 64'd5, 6'd0);
        issue(ACT_STOP, 16'h0000, 64'd5, 6'd0);
        issue(ACT_START, 16'h0000, 64'd100, 6'd0);
        issue(ACT_STOP, 16'h0000, 64'd150, 6'd0);
        issue(ACT_START, 16'h0000, 64'd200, 6'd0);
        issue(ACT_STOP, 16'h0000, 64'd250, 6'd0);
        issue(ACT_READ, 16'h0000, '0, 6'd0);
        issue(ACT_READ, 16'h0000, '0, 6'd1);
        issue(ACT_READ, 16'hFFFF, TIME_MAX, 6'h3F);
        issue(ACT_STOP, 16'h5A5A, 64'd300, 6'd0);
        issue(ACT_START, 16'hA5A5, 64'hAAAA_AAAA_AAAA_AAAA, 6'h15);
        issue(ACT_CLEAR, 16'hFFFF, TIME_MAX, 6'h3F);
        issue(ACT_READ, 16'h0000, '0, 6'd0);
        issue(ACT_STOP, 16'h0000, 64'd400, 6'd0);
        issue(ACT_START, 16'h0001, '0, 6'd0);
        issue(ACT_READ, 16'h0001, '0, 6'd0);

        pause_until_drained();
        fill_table();

        while (sent_count < 800) begin
            quiet_phase = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 75) run_session();
            else if (pick < 87) issue_noise();
            else if (pick < 92) fill_table();
            else pause_until_drained();
        end

        quiet_phase = 0;
        pause_until_drained();
        repeat (NSLOTS + 16) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("[tagged_interval_profiler_unit] OK");
        end else begin
            $display("[tagged_interval_profiler_unit] ERROR");
        end
        $finish;
    end

endmodule
